@@ hw/rtl/dsrg_pkg.sv @@
// Shared constants and control types of the dual stepper rate generator.
`default_nettype none
package dsrg_pkg;

	// Phase increment per issued step.
	localparam int unsigned PHASE_STEP = 80;

	localparam int unsigned SPEED_W = 16;
	localparam int unsigned RATE_W  = 15;
	localparam int unsigned TIME_W  = 16;
	localparam int unsigned STEPS_W = 10;
	localparam int unsigned ODO_W   = 32;
	localparam int unsigned PHASE_W = $clog2(PHASE_STEP);
	// Working phase: holds phase minus the largest rate, plus a sign bit.
	localparam int unsigned ACC_W   = RATE_W + 2;

	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 88;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPEED        = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_STOP_TIMEOUT     = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_POWEROFF_TIMEOUT = 2'd2;

	localparam logic [RATE_W-1:0] MAX_SPEED_RST        = 15'd8192;
	localparam logic [TIME_W-1:0] STOP_TIMEOUT_RST     = 16'd1220;
	localparam logic [TIME_W-1:0] POWEROFF_TIMEOUT_RST = 16'd6100;

	// Request kinds carried on the input tuser.
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	typedef struct packed {
		logic set;     // store saturated speeds, reload stop countdown
		logic tick;    // run countdowns, load working phases
		logic step;    // one accumulation step on each negative phase
		logic finish;  // commit phases and odometry, load the result
	} cmd_t;

	typedef struct packed {
		logic done;      // both working phases are non-negative
		logic out_busy;  // result register full and not taken this cycle
	} stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/dsrg_ctrl.sv @@
// Controller state machine that sequences set and tick items.
`default_nettype none
module dsrg_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	input  wire              s_tuser,
	output logic             s_tready,
	input  dsrg_pkg::stat_t  status,
	output dsrg_pkg::cmd_t   cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == dsrg_pkg::REQ_SET) begin
						cmd.set = 1'b1;
					end else begin
						cmd.tick = 1'b1;
						state_d  = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (!status.done) begin
					cmd.step = 1'b1;
				end else if (!status.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/dsrg_dp.sv @@
// Datapath: configuration, motor state, step accumulators and result register.
`default_nettype none
module dsrg_dp (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire  [dsrg_pkg::CFG_ADDR_W-1:0]        cfg_addr,
	input  wire  [dsrg_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  wire  [dsrg_pkg::IN_DATA_W-1:0]         in_data,
	input  dsrg_pkg::cmd_t                         cmd,
	output dsrg_pkg::stat_t                        status,
	output logic                                   m_tvalid,
	input  wire                                    m_tready,
	output logic [dsrg_pkg::OUT_DATA_W-1:0]        m_tdata
);

	localparam int unsigned RW  = dsrg_pkg::RATE_W;
	localparam int unsigned AW  = dsrg_pkg::ACC_W;
	localparam int unsigned PW  = dsrg_pkg::PHASE_W;
	localparam int unsigned TW  = dsrg_pkg::TIME_W;
	localparam int unsigned SW  = dsrg_pkg::STEPS_W;
	localparam int unsigned OW  = dsrg_pkg::ODO_W;
	localparam int unsigned VW  = dsrg_pkg::SPEED_W;

	// Saturates a signed speed to +/- lim; returns {forward, magnitude}.
	function automatic logic [RW:0] sat_speed(input logic [VW-1:0] s,
			input logic [RW-1:0] lim);
		logic signed [VW:0] sx;
		logic signed [VW:0] lp;
		logic signed [VW:0] ln;
		logic signed [VW:0] r;
		logic        [VW:0] mag;
		sx = $signed({s[VW-1], s});
		lp = $signed({{(VW+1-RW){1'b0}}, lim});
		ln = -lp;
		r  = sx;
		if (sx > lp) begin
			r = lp;
		end else if (sx < ln) begin
			r = ln;
		end
		mag = r[VW] ? (VW+1)'(-r) : (VW+1)'(r);
		return {~r[VW], mag[RW-1:0]};
	endfunction

	logic [RW-1:0] max_speed_q;
	logic [TW-1:0] stop_timeout_q;
	logic [TW-1:0] poweroff_timeout_q;
	logic [TW-1:0] stop_cnt_q;
	logic [TW-1:0] poff_cnt_q;
	logic          fwd1_q, fwd2_q;
	logic [RW-1:0] rate1_q, rate2_q;
	logic [PW-1:0] phase1_q, phase2_q;
	logic [AW-1:0] acc1_q, acc2_q;
	logic [SW-1:0] cnt1_q, cnt2_q;
	logic [OW-1:0] odo1_q, odo2_q;
	logic          en_q;
	logic          out_valid_q;
	logic [dsrg_pkg::OUT_DATA_W-1:0] out_data_q;

	logic [RW:0]   sat1, sat2;
	logic          stop_zero;
	logic [RW-1:0] rate1_eff, rate2_eff;
	logic [AW-1:0] acc1_init, acc2_init;
	logic [OW-1:0] odo1_next, odo2_next;

	assign sat1 = sat_speed(in_data[VW-1:0], max_speed_q);
	assign sat2 = sat_speed(in_data[2*VW-1:VW], max_speed_q);

	// An expired stop countdown clears both rates before this tick's steps.
	assign stop_zero = (stop_cnt_q == '0);
	assign rate1_eff = stop_zero ? '0 : rate1_q;
	assign rate2_eff = stop_zero ? '0 : rate2_q;
	assign acc1_init = {{(AW-PW){1'b0}}, phase1_q} - {{(AW-RW){1'b0}}, rate1_eff};
	assign acc2_init = {{(AW-PW){1'b0}}, phase2_q} - {{(AW-RW){1'b0}}, rate2_eff};

	assign odo1_next = fwd1_q ? odo1_q + OW'(cnt1_q) : odo1_q - OW'(cnt1_q);
	assign odo2_next = fwd2_q ? odo2_q + OW'(cnt2_q) : odo2_q - OW'(cnt2_q);

	assign status.done     = !acc1_q[AW-1] && !acc2_q[AW-1];
	assign status.out_busy = out_valid_q && !m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q        <= dsrg_pkg::MAX_SPEED_RST;
			stop_timeout_q     <= dsrg_pkg::STOP_TIMEOUT_RST;
			poweroff_timeout_q <= dsrg_pkg::POWEROFF_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				dsrg_pkg::REG_MAX_SPEED:        max_speed_q        <= cfg_wdata[RW-1:0];
				dsrg_pkg::REG_STOP_TIMEOUT:     stop_timeout_q     <= cfg_wdata[TW-1:0];
				dsrg_pkg::REG_POWEROFF_TIMEOUT: poweroff_timeout_q <= cfg_wdata[TW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd1_q     <= 1'b1;
			fwd2_q     <= 1'b1;
			rate1_q    <= '0;
			rate2_q    <= '0;
			phase1_q   <= '0;
			phase2_q   <= '0;
			acc1_q     <= '0;
			acc2_q     <= '0;
			cnt1_q     <= '0;
			cnt2_q     <= '0;
			odo1_q     <= '0;
			odo2_q     <= '0;
			stop_cnt_q <= '0;
			poff_cnt_q <= '0;
			en_q       <= 1'b0;
		end else begin
			if (cmd.set) begin
				fwd1_q     <= sat1[RW];
				rate1_q    <= sat1[RW-1:0];
				fwd2_q     <= sat2[RW];
				rate2_q    <= sat2[RW-1:0];
				stop_cnt_q <= stop_timeout_q;
			end
			if (cmd.tick) begin
				rate1_q <= rate1_eff;
				rate2_q <= rate2_eff;
				if (!stop_zero) begin
					stop_cnt_q <= stop_cnt_q - 1'b1;
				end
				if (rate1_eff == '0 && rate2_eff == '0) begin
					if (poff_cnt_q == '0) begin
						en_q <= 1'b0;
					end else begin
						poff_cnt_q <= poff_cnt_q - 1'b1;
						en_q       <= 1'b1;
					end
				end else begin
					poff_cnt_q <= poweroff_timeout_q;
					en_q       <= 1'b1;
				end
				acc1_q <= acc1_init;
				acc2_q <= acc2_init;
				cnt1_q <= '0;
				cnt2_q <= '0;
			end
			if (cmd.step) begin
				if (acc1_q[AW-1]) begin
					acc1_q <= acc1_q + AW'(dsrg_pkg::PHASE_STEP);
					cnt1_q <= cnt1_q + 1'b1;
				end
				if (acc2_q[AW-1]) begin
					acc2_q <= acc2_q + AW'(dsrg_pkg::PHASE_STEP);
					cnt2_q <= cnt2_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				phase1_q <= acc1_q[PW-1:0];
				phase2_q <= acc2_q[PW-1:0];
				odo1_q   <= odo1_next;
				odo2_q   <= odo2_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= {1'b0, odo2_next, odo1_next, cnt2_q, cnt1_q, fwd2_q, fwd1_q, en_q};
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/dual_stepper_rate_generator_core.sv @@
// Top level of the dual stepper rate generator: controller plus datapath.
// Set: stored at the transfer, no result. Tick: the transfer loads the working phases,
// then the one-step-per-cycle accumulator loop runs N steps, N the larger step count
// of both motors (at most 410); the next item is taken once the result is registered.
// Reset (arst_n low) restores register defaults, forward directions, zero rates, phases
// and odometry, and an empty result register.
`default_nettype none
module dual_stepper_rate_generator_core (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [dsrg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire  [dsrg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// speed_first[15:0], speed_second[31:16]
	input  wire  [dsrg_pkg::IN_DATA_W-1:0]     s_tdata,
	// req_type[0]
	input  wire                                s_tuser,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// drivers_enabled[0], dir_first[1], dir_second[2], steps_first[12:3],
	// steps_second[22:13], odometry_first[54:23], odometry_second[86:55], zero[87]
	output logic [dsrg_pkg::OUT_DATA_W-1:0]    m_tdata
);

	dsrg_pkg::cmd_t  cmd;
	dsrg_pkg::stat_t status;

	dsrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	dsrg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire
